>>> rtl/lift_dispatch_min_cost_assert.svh
// Assertion macros used by the lift dispatcher back end.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef LIFT_DISPATCH_MIN_COST_ASSERT_SVH
`define LIFT_DISPATCH_MIN_COST_ASSERT_SVH
`ifndef SYNTHESIS
`define LDMC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("lift dispatch check failed");
`define LDMC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("lift dispatch check failed");
`else
`define LDMC_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define LDMC_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> rtl/ldmc_pkg.sv
// Shared types and constants for the lift dispatcher.
// No dependencies.
package ldmc_pkg;

	localparam int LIFT_W         = 11;
	localparam int FIELD_FLOOR_W  = 16;
	localparam int COST_W         = 17;
	localparam int MAX_LIFTS_DEF  = 1024;
	localparam int FLOOR_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [COST_W-1:0] COST_MAX = 17'h1FFFF;
	localparam logic              OP_LOAD  = 1'b0;
	localparam logic              OP_QUERY = 1'b1;

	typedef struct packed {
		logic                            operation;
		logic [LIFT_W-1:0]               lift_number;
		logic signed [FIELD_FLOOR_W-1:0] lift_start;
		logic signed [FIELD_FLOOR_W-1:0] lift_end;
		logic signed [FIELD_FLOOR_W-1:0] trip_from;
		logic signed [FIELD_FLOOR_W-1:0] trip_to;
	} in_item_t;

	typedef struct packed {
		logic [LIFT_W-1:0] best_lift;
		logic [COST_W-1:0] best_cost;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_SKIP,
		CMD_LOAD,
		CMD_QUERY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		in_item_t  item;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DONE
	} back_state_t;

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_ET,
		SEL_TF,
		SEL_FE_TF
	} cost_sel_t;

endpackage

>>> rtl/lift_dispatch_min_cost.sv
// Top level of the minimum-cost lift dispatcher.
// Depends on ldmc_pkg, ldmc_front and ldmc_back.
//
//  channel | signals                        | carries
//  in      | in_valid, in_ready, in_data    | load or query item (in_item_t)
//  out     | out_valid, out_ready, out_data | best lift and cost (out_item_t)
//  cfg     | cfg_valid, cfg_ready, cfg_data | lift_count, always ready
//
// A load is written to the table while the back end stays idle; a query scans n lifts,
// n being lift_count capped at MAX_LIFTS: one read per lift on the single table read port,
// then the three cost stages drain, the back end sees them empty and loads the output.
// A two-entry queue lets the front keep taking items while a scan runs.
// The floor table is not cleared on reset; no start-up pass is needed.
// A finished result waits in the output register while the back end stalls.
module lift_dispatch_min_cost #(
	parameter int MAX_LIFTS  = ldmc_pkg::MAX_LIFTS_DEF,
	parameter int FLOOR_BITS = ldmc_pkg::FLOOR_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  ldmc_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output ldmc_pkg::out_item_t         out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ldmc_pkg::LIFT_W-1:0] cfg_data
);
	import ldmc_pkg::*;

	logic              q_valid;
	logic              q_ready;
	cmd_t              q_data;
	logic [LIFT_W-1:0] lift_count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lift_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			lift_count_q <= cfg_data;
		end
	end

	ldmc_front #(
		.MAX_LIFTS (MAX_LIFTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_data   (q_data)
	);

	ldmc_back #(
		.MAX_LIFTS  (MAX_LIFTS),
		.FLOOR_BITS (FLOOR_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.lift_count (lift_count_q),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_data     (q_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

>>> rtl/ldmc_front.sv
// Front end: accepts input transfers, classifies them and queues them.
// Depends on ldmc_pkg.
module ldmc_front #(
	parameter int MAX_LIFTS = ldmc_pkg::MAX_LIFTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ldmc_pkg::in_item_t in_data,
	output logic              q_valid,
	input  logic              q_ready,
	output ldmc_pkg::cmd_t    q_data
);
	import ldmc_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NUM_W = LIFT_W + 2;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	cmd_t              cmd_in;
	logic              push;
	logic              pop;
	logic [NUM_W-1:0]  num_ext;

	assign num_ext = {2'b00, in_data.lift_number};

	always_comb begin
		cmd_in.item = in_data;
		if (in_data.operation == OP_QUERY) begin
			cmd_in.kind = CMD_QUERY;
		end else if (num_ext >= NUM_W'(1) && num_ext <= NUM_W'(MAX_LIFTS)) begin
			cmd_in.kind = CMD_LOAD;
		end else begin
			cmd_in.kind = CMD_SKIP;
		end
	end

	assign in_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_data   = entry_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

>>> rtl/ldmc_back.sv
// Back end: floor table, lift scan with cost pipeline, result register.
// Depends on ldmc_pkg and lift_dispatch_min_cost_assert.svh.
`include "lift_dispatch_min_cost_assert.svh"
module ldmc_back #(
	parameter int MAX_LIFTS  = ldmc_pkg::MAX_LIFTS_DEF,
	parameter int FLOOR_BITS = ldmc_pkg::FLOOR_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ldmc_pkg::LIFT_W-1:0] lift_count,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  ldmc_pkg::cmd_t              q_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output ldmc_pkg::out_item_t         out_data
);
	import ldmc_pkg::*;

	localparam int FB    = FLOOR_BITS;
	localparam int AW    = (MAX_LIFTS > 1) ? $clog2(MAX_LIFTS) : 1;
	localparam int NW    = $clog2(MAX_LIFTS + 2);
	localparam int CMP_W = (NW > LIFT_W) ? NW : LIFT_W;
	localparam int DW    = FB + 1;
	localparam int SUM_W = FB + 2;
	localparam int SAT_W = (SUM_W > COST_W) ? SUM_W : COST_W;

	function automatic logic signed [FB-1:0] to_floor(input logic [FIELD_FLOOR_W-1:0] raw);
		logic [FB+FIELD_FLOOR_W-1:0] ext;
		ext = {{FB{1'b0}}, raw};
		return ext[FB-1:0];
	endfunction

	function automatic logic [DW-1:0] floor_dist(input logic signed [FB-1:0] a,
			input logic signed [FB-1:0] b);
		logic signed [DW-1:0] ax;
		logic signed [DW-1:0] bx;
		ax = {a[FB-1], a};
		bx = {b[FB-1], b};
		return (ax > bx) ? DW'(ax - bx) : DW'(bx - ax);
	endfunction

	back_state_t          st_q, st_d;
	logic                 pop, do_wr, start, issue, finish;

	logic [2*FB-1:0]      mem [MAX_LIFTS];
	logic [AW-1:0]        waddr;
	logic [AW-1:0]        raddr;
	logic [NW-1:0]        n_d;
	logic [CMP_W-1:0]     cnt_ext;

	logic [NW-1:0]        n_q;
	logic [NW-1:0]        iss_q;
	logic signed [FB-1:0] f_q, t_q;
	logic                 t_up_q, t_dn_q;
	logic [DW-1:0]        dist_tf_q;

	logic                 v_s1, v_s2, v_s3;
	logic [2*FB-1:0]      rd_s1;
	logic [NW-1:0]        idx_s1, idx_s2, idx_s3;
	cost_sel_t            sel_s2;
	logic [DW-1:0]        dist_fe_s2, dist_et_s2;
	logic [COST_W-1:0]    cost_s3;

	logic [NW-1:0]        best_idx_q;
	logic [COST_W-1:0]    best_cost_q;
	logic                 out_valid_q;
	out_item_t            out_data_q;

	logic signed [FB-1:0] fl_a, fl_b, s_w, e_w;
	logic                 l_up, l_dn, f_in, t_in, beyond, dir_diff;
	cost_sel_t            sel_w;
	logic [SUM_W-1:0]     sum_w;
	logic [SAT_W-1:0]     sum_ext;
	logic [COST_W-1:0]    sum_sat;
	logic [COST_W-1:0]    cost_w;
	logic [NW+LIFT_W-1:0] best_ext;

	// state register and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d   = st_q;
		pop    = 1'b0;
		do_wr  = 1'b0;
		start  = 1'b0;
		issue  = 1'b0;
		finish = 1'b0;
		case (st_q)
			BK_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					if (q_data.kind == CMD_LOAD) begin
						do_wr = 1'b1;
					end
					if (q_data.kind == CMD_QUERY) begin
						start = 1'b1;
						st_d  = BK_SCAN;
					end
				end
			end
			BK_SCAN: begin
				if (iss_q <= n_q) begin
					issue = 1'b1;
				end else if (!v_s1 && !v_s2 && !v_s3) begin
					st_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!out_valid_q || out_ready) begin
					finish = 1'b1;
					st_d   = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	assign q_ready = pop;

	// table
	assign fl_a  = to_floor(q_data.item.lift_start);
	assign fl_b  = to_floor(q_data.item.lift_end);
	assign waddr = AW'(q_data.item.lift_number - 1'b1);
	assign raddr = AW'(iss_q - 1'b1);

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[waddr] <= {fl_a, fl_b};
		end
		if (issue) begin
			rd_s1 <= mem[raddr];
		end
	end

	// scan control
	assign cnt_ext = CMP_W'(lift_count);
	assign n_d     = (cnt_ext > CMP_W'(MAX_LIFTS)) ? NW'(MAX_LIFTS) : NW'(cnt_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			iss_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				n_q   <= n_d;
				iss_q <= NW'(1);
			end else if (issue) begin
				iss_q <= iss_q + 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// cost classification
	assign s_w      = rd_s1[2*FB-1:FB];
	assign e_w      = rd_s1[FB-1:0];
	assign l_up     = s_w < e_w;
	assign l_dn     = s_w > e_w;
	assign dir_diff = (l_up != t_up_q) || (l_dn != t_dn_q);
	assign f_in     = (l_up && s_w <= f_q && f_q <= e_w) || (l_dn && e_w <= f_q && f_q <= s_w);
	assign t_in     = (l_up && s_w <= t_q && t_q <= e_w) || (l_dn && e_w <= t_q && t_q <= s_w);
	assign beyond   = (l_dn && t_q <= e_w) || (l_up && t_q >= e_w);

	always_comb begin
		if (dir_diff) begin
			sel_w = SEL_FE_TF;
		end else if (f_in && t_in) begin
			sel_w = SEL_ZERO;
		end else if (f_in && beyond) begin
			sel_w = SEL_ET;
		end else if ((!l_up && !l_dn) || !f_in) begin
			sel_w = SEL_FE_TF;
		end else begin
			sel_w = SEL_TF;
		end
	end

	// cost value with saturation
	assign sum_w   = SUM_W'(dist_fe_s2) + SUM_W'(dist_tf_q);
	assign sum_ext = SAT_W'(sum_w);
	assign sum_sat = (sum_ext > SAT_W'(COST_MAX)) ? COST_MAX : COST_W'(sum_ext);

	always_comb begin
		case (sel_s2)
			SEL_ZERO:  cost_w = '0;
			SEL_ET:    cost_w = (SAT_W'(dist_et_s2) > SAT_W'(COST_MAX)) ?
					COST_MAX : COST_W'(SAT_W'(dist_et_s2));
			SEL_TF:    cost_w = (SAT_W'(dist_tf_q) > SAT_W'(COST_MAX)) ?
					COST_MAX : COST_W'(SAT_W'(dist_tf_q));
			default:   cost_w = sum_sat;
		endcase
	end

	assign best_ext = {{LIFT_W{1'b0}}, best_idx_q};

	always_ff @(posedge clk) begin
		if (start) begin
			f_q         <= to_floor(q_data.item.trip_from);
			t_q         <= to_floor(q_data.item.trip_to);
			t_up_q      <= to_floor(q_data.item.trip_from) < to_floor(q_data.item.trip_to);
			t_dn_q      <= to_floor(q_data.item.trip_from) > to_floor(q_data.item.trip_to);
			dist_tf_q   <= floor_dist(to_floor(q_data.item.trip_to),
					to_floor(q_data.item.trip_from));
			best_idx_q  <= '0;
			best_cost_q <= COST_MAX;
		end else if (v_s3 && (best_idx_q == '0 || cost_s3 < best_cost_q)) begin
			best_idx_q  <= idx_s3;
			best_cost_q <= cost_s3;
		end
		idx_s1     <= iss_q;
		idx_s2     <= idx_s1;
		idx_s3     <= idx_s2;
		sel_s2     <= sel_w;
		dist_fe_s2 <= floor_dist(f_q, e_w);
		dist_et_s2 <= floor_dist(e_w, t_q);
		cost_s3    <= cost_w;
		if (finish) begin
			out_data_q.best_lift <= best_ext[LIFT_W-1:0];
			out_data_q.best_cost <= best_cost_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`LDMC_ASSERT_IMP(a_rise_after_done, clk, arst_n, $rose(out_valid_q), $past(st_q) == BK_DONE)
	`LDMC_ASSERT_IMP(a_pipe_in_scan, clk, arst_n, v_s3, st_q == BK_SCAN)
	`LDMC_ASSERT_IMP(a_issue_bound, clk, arst_n, st_q == BK_SCAN, iss_q <= n_q + 1'b1)
	`LDMC_ASSERT_IMP(a_none_max, clk, arst_n,
		out_valid_q && out_data_q.best_lift == '0, out_data_q.best_cost == COST_MAX)

endmodule
